// ===== rtl/core/fcms_pkg.sv =====
`default_nettype none
package fcms_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [63:0] SEED_RESET     = 64'd77;
  localparam logic [63:0] KEY_LEN        = 64'd13;

  localparam logic [63:0] XP1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] XP2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] XP3 = 64'h165667B19E3779F9;
  localparam logic [63:0] XP4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] XP5 = 64'h27D4EB2F165667C5;

  // Flow key fields, wire order
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
  } fcms_key_t;

  // Hash program steps, one 64-bit multiply each
  typedef enum logic [3:0] {
    HOP_LANE_MUL  = 4'd0,
    HOP_LANE_MIX  = 4'd1,
    HOP_LANE_RND  = 4'd2,
    HOP_WORD_MUL  = 4'd3,
    HOP_WORD_RND  = 4'd4,
    HOP_BYTE_MUL  = 4'd5,
    HOP_BYTE_RND  = 4'd6,
    HOP_AVAL_A    = 4'd7,
    HOP_AVAL_B    = 4'd8
  } hash_op_t;

  // Phases of one multiply step
  typedef enum logic [2:0] {
    HPH_LOAD = 3'd0,
    HPH_LL   = 3'd1,
    HPH_HL   = 3'd2,
    HPH_LH   = 3'd3,
    HPH_POST = 3'd4
  } hash_ph_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_HASH  = 3'd2,
    ST_MOD   = 3'd3,
    ST_READ  = 3'd4,
    ST_WRITE = 3'd5,
    ST_DONE  = 3'd6
  } fcms_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/fcms_if.sv =====
`default_nettype none
interface fcms_pkt_if;
  logic        valid;
  logic        ready;
  logic [15:0] ether_type;
  logic [7:0]  ip_protocol;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [15:0] source_port;
  logic [15:0] destination_port;

  modport source (output valid, ether_type, ip_protocol, source_address,
                  destination_address, source_port, destination_port,
                  input ready);
  modport sink (input valid, ether_type, ip_protocol, source_address,
                destination_address, source_port, destination_port,
                output ready);
endinterface

interface fcms_res_if;
  logic        valid;
  logic        ready;
  logic        counted;
  logic [63:0] flow_hash;
  logic [63:0] min_count;

  modport source (output valid, counted, flow_hash, min_count, input ready);
  modport sink (input valid, counted, flow_hash, min_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fcms_hash.sv =====
`default_nettype none
module fcms_hash import fcms_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire fcms_key_t   key,
  input  wire logic [63:0] seed,
  output logic             done,
  output logic [63:0]      hash
);

  logic        busy;
  hash_op_t    op;
  hash_ph_t    ph;
  fcms_key_t   key_q;
  logic [63:0] h;
  logic [63:0] k;
  logic [63:0] opa;
  logic [63:0] prod;
  logic [63:0] lane0;
  logic [63:0] lane4;
  logic [63:0] byte12;
  logic [63:0] operand;
  logic [63:0] cnst;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  // Little-endian lanes of the 13-byte key
  assign lane0  = {key_q.dst[7:0], key_q.dst[15:8], key_q.dst[23:16], key_q.dst[31:24],
                   key_q.src[7:0], key_q.src[15:8], key_q.src[23:16], key_q.src[31:24]};
  assign lane4  = {32'd0, key_q.dport[7:0], key_q.dport[15:8],
                   key_q.sport[7:0], key_q.sport[15:8]};
  assign byte12 = {56'd0, key_q.proto};

  // Select operand and multiplier constant of the current step
  always_comb begin
    operand = 64'd0;
    cnst    = XP1;
    case (op)
      HOP_LANE_MUL: begin operand = lane0; cnst = XP2; end
      HOP_LANE_MIX: begin operand = k; cnst = XP1; end
      HOP_LANE_RND: begin operand = {h[36:0], h[63:37]}; cnst = XP1; end
      HOP_WORD_MUL: begin operand = lane4; cnst = XP1; end
      HOP_WORD_RND: begin operand = {h[40:0], h[63:41]}; cnst = XP2; end
      HOP_BYTE_MUL: begin operand = byte12; cnst = XP5; end
      HOP_BYTE_RND: begin operand = {h[52:0], h[63:53]}; cnst = XP1; end
      HOP_AVAL_A:   begin operand = h ^ (h >> 33); cnst = XP2; end
      HOP_AVAL_B:   begin operand = h ^ (h >> 29); cnst = XP3; end
      default:      begin operand = 64'd0; cnst = XP1; end
    endcase
  end

  // One shared 32x32 multiplier, three partial products per step
  always_comb begin
    mul_a = opa[31:0];
    mul_b = cnst[31:0];
    case (ph)
      HPH_HL:  begin mul_a = opa[63:32]; mul_b = cnst[31:0]; end
      HPH_LH:  begin mul_a = opa[31:0];  mul_b = cnst[63:32]; end
      default: begin mul_a = opa[31:0];  mul_b = cnst[31:0]; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Sequence steps and phases
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op   <= HOP_LANE_MUL;
      ph   <= HPH_LOAD;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        op    <= HOP_LANE_MUL;
        ph    <= HPH_LOAD;
        key_q <= key;
        h     <= seed + XP5 + KEY_LEN;
      end else if (busy) begin
        case (ph)
          HPH_LOAD: begin opa <= operand; ph <= HPH_LL; end
          HPH_LL:   begin prod <= mul_p; ph <= HPH_HL; end
          HPH_HL:   begin prod <= prod + {mul_p[31:0], 32'd0}; ph <= HPH_LH; end
          HPH_LH:   begin prod <= prod + {mul_p[31:0], 32'd0}; ph <= HPH_POST; end
          HPH_POST: begin
            ph <= HPH_LOAD;
            op <= hash_op_t'(op + 4'd1);
            case (op)
              HOP_LANE_MUL: k <= {prod[32:0], prod[63:33]};
              HOP_LANE_RND: h <= prod + XP4;
              HOP_WORD_RND: h <= prod + XP3;
              HOP_BYTE_RND: h <= prod;
              HOP_AVAL_A:   h <= prod;
              HOP_AVAL_B: begin
                h    <= prod ^ (prod >> 32);
                busy <= 1'b0;
                done <= 1'b1;
              end
              default:      h <= h ^ prod;
            endcase
          end
          default: ph <= HPH_LOAD;
        endcase
      end
    end
  end

  assign hash = h;

endmodule
`default_nettype wire

// ===== rtl/core/flow_count_min_sketch_update_unit.sv =====
`default_nettype none
// Channel | Dir | Beat contents
// pkt     | in  | ether_type, ip_protocol, addresses, ports
// res     | out | counted, flow_hash, min_count
// cfg     | in  | cfg_we, cfg_data: hash seed
// A UDP/IPv4 beat is accepted, then hashed: nine 64-bit multiplies run through one
// 32x32 multiplier, each in the phases load, LL, HL, LH and post, and done is raised.
// Then come the column reduction by reciprocal multiply, a read and a write per row
// on the sketch memory, and the result load. Other beats go from acceptance straight
// to the result load. After reset a clearing pass zeroes all ROWS*COLUMNS_PER_ROW
// sketch words; pkt.ready stays low meanwhile. A stalled result holds in the output
// register while the next beat is taken and worked on; a second result waits behind it.
module flow_count_min_sketch_update_unit import fcms_pkg::*; #(
  parameter int ROWS            = 4,
  parameter int COLUMNS_PER_ROW = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  fcms_pkt_if.sink         pkt,
  fcms_res_if.source       res,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_data
);

  localparam int DEPTH = ROWS * COLUMNS_PER_ROW;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (COLUMNS_PER_ROW > 1) ? $clog2(COLUMNS_PER_ROW) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [16:0] COLS17 = 17'(COLUMNS_PER_ROW);
  localparam logic [31:0] RECIP  =
    32'(((64'd1 << 32) + 64'(COLUMNS_PER_ROW) - 64'd1) / 64'(COLUMNS_PER_ROW));

  fcms_state_t state, state_next;
  logic [63:0] seed;
  logic        accept;
  logic        match;
  logic        hash_start;
  logic        hash_done;
  logic [63:0] hash;
  fcms_key_t   key;

  logic [15:0] slice [ROWS];
  logic [15:0] quot  [ROWS];
  logic [15:0] rem   [ROWS];
  logic        mod_phase;
  logic [RW-1:0] row;
  logic [AW-1:0] addr;
  logic [AW-1:0] addr_q;
  logic [AW-1:0] clr_addr;
  logic [63:0] best;
  logic [63:0] hash_q;
  logic        counted_q;
  logic [63:0] inc;
  logic        load_out;

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0] mem_wdata;

  logic        out_valid;
  logic        out_counted;
  logic [63:0] out_hash;
  logic [63:0] out_min;

  assign accept = pkt.valid && pkt.ready;
  assign match  = (pkt.ether_type == ETHERTYPE_IPV4) && (pkt.ip_protocol == PROTO_UDP);
  assign hash_start = accept && match;
  assign key = '{src: pkt.source_address, dst: pkt.destination_address,
                 sport: pkt.source_port, dport: pkt.destination_port,
                 proto: pkt.ip_protocol};

  fcms_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (key),
    .seed  (seed),
    .done  (hash_done),
    .hash  (hash)
  );

  // Seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (cfg_we) begin
      seed <= cfg_data;
    end
  end

  // Sketch address of the current row
  assign addr = AW'(row) * AW'(COLUMNS_PER_ROW) + AW'(rem[row][CW-1:0]);
  assign inc  = (rdata == '1) ? rdata : rdata + 64'd1;

  // Next state and strobes
  always_comb begin
    state_next = state;
    pkt.ready  = 1'b0;
    load_out   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = addr_q;
    mem_wdata  = inc;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = 64'd0;
        if (clr_addr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        pkt.ready = 1'b1;
        if (accept) state_next = match ? ST_HASH : ST_DONE;
      end
      ST_HASH: begin
        if (hash_done) state_next = ST_MOD;
      end
      ST_MOD: begin
        if (mod_phase) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        mem_we = 1'b1;
        state_next = (row == RW'(ROWS - 1)) ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        if (!out_valid || res.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sketch memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[addr];
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: clr_addr <= clr_addr + AW'(1);
        ST_IDLE: begin
          counted_q <= match;
          hash_q    <= 64'd0;
          best      <= 64'd0;
        end
        ST_HASH: begin
          hash_q    <= hash;
          mod_phase <= 1'b0;
          for (int r = 0; r < ROWS; r++) begin
            slice[r] <= hash[16*r +: 16];
          end
        end
        ST_MOD: begin
          // quotient by reciprocal multiply, then remainder, in every row lane
          for (int r = 0; r < ROWS; r++) begin
            if (!mod_phase) begin
              quot[r] <= 16'((48'(slice[r]) * 48'(RECIP)) >> 32);
            end else begin
              rem[r] <= 16'({1'b0, slice[r]} - 17'(quot[r] * COLS17));
            end
          end
          mod_phase <= 1'b1;
          row       <= '0;
          best      <= '1;
        end
        ST_READ: addr_q <= addr;
        ST_WRITE: begin
          if (inc < best) best <= inc;
          row <= row + RW'(1);
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid   <= 1'b1;
      out_counted <= counted_q;
      out_hash    <= hash_q;
      out_min     <= best;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign res.valid     = out_valid;
  assign res.counted   = out_counted;
  assign res.flow_hash = out_hash;
  assign res.min_count = out_min;

endmodule
`default_nettype wire

// ===== rtl/core/fcms_checker.sv =====
`default_nettype none
module fcms_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        pkt_valid,
  input wire logic        pkt_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic        counted,
  input wire logic [63:0] flow_hash,
  input wire logic [63:0] min_count
);

  // Hold a stalled result beat
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped while stalled");

  // Uncounted beats carry zeros
  a_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !counted |-> (flow_hash == 64'd0) && (min_count == 64'd0))
    else $error("uncounted beat with nonzero payload");

  // A counted flow has been seen at least once
  a_min: assert property (@(posedge clk) disable iff (rst)
    res_valid && counted |-> min_count != 64'd0)
    else $error("counted beat with zero estimate");

  // No beat leaves right after reset
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !res_valid && !(pkt_valid && pkt_ready))
    else $error("activity right after reset");

endmodule

bind flow_count_min_sketch_update_unit fcms_checker u_fcms_checker (
  .clk       (clk),
  .rst       (rst),
  .pkt_valid (pkt.valid),
  .pkt_ready (pkt.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .counted   (res.counted),
  .flow_hash (res.flow_hash),
  .min_count (res.min_count)
);
`default_nettype wire
